/* rtl/core/wels_pkg.sv */
package wels_pkg;

	// Table sizes.
	localparam int TABLE_SLOTS  = 64;
	localparam int MAX_VERTICES = 64;
	localparam int IDX_W        = $clog2(TABLE_SLOTS);
	localparam int CNT_W        = 7;
	localparam int VTX_W        = 6;
	localparam int WGT_W        = 32;
	localparam int ADDR_W       = 4;

	// Operation codes.
	localparam logic [2:0] F_ADD    = 3'd0;
	localparam logic [2:0] F_REMOVE = 3'd1;
	localparam logic [2:0] F_LOOKUP = 3'd2;
	localparam logic [2:0] F_NBR    = 3'd3;
	localparam logic [2:0] F_LIST   = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic [1:0] ST_BADV = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_DIRECTED = 2'd0;
	localparam logic [1:0] REG_VCOUNT   = 2'd1;
	localparam logic [1:0] REG_ELIMIT   = 2'd2;

	// One edge slot as it travels along the ring of cells.
	typedef struct packed {
		logic              valid;
		logic [VTX_W-1:0]  from_v;
		logic [VTX_W-1:0]  to_v;
		logic [WGT_W-1:0]  weight;
	} slot_t;

endpackage

/* rtl/core/wels_cell.sv */
module wels_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift_en,
	input  logic            load_en,
	input  wels_pkg::slot_t load_data,
	input  wels_pkg::slot_t shift_in,
	output wels_pkg::slot_t slot_q
);
	import wels_pkg::*;

	logic             valid_q;
	logic [VTX_W-1:0] from_q;
	logic [VTX_W-1:0] to_q;
	logic [WGT_W-1:0] weight_q;

	// Valid bit is control state and clears on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_en) begin
			valid_q <= 1'b1;
		end else if (shift_en) begin
			valid_q <= shift_in.valid;
		end
	end

	// Edge contents load on an add or move one place along the ring.
	always_ff @(posedge clk) begin
		if (load_en) begin
			from_q   <= load_data.from_v;
			to_q     <= load_data.to_v;
			weight_q <= load_data.weight;
		end else if (shift_en) begin
			from_q   <= shift_in.from_v;
			to_q     <= shift_in.to_v;
			weight_q <= shift_in.weight;
		end
	end

	assign slot_q = '{valid: valid_q, from_v: from_q, to_v: to_q, weight: weight_q};

endmodule

/* rtl/core/weighted_edge_list_store.sv */
// Add, bad vertex and unused codes: the word is registered from the finish
// state, and the next item is taken once the block is idle again.
// Remove, lookup, neighbours and list: the ring of 64 cells rotates once past
// the head cell, held while the output stalls, and the last word is registered
// from the finish state. One item is in work at a time.
// Reset clears all valid bits and the fill count and sets undirected mode, 64 vertices and an edge limit of 64.
module weighted_edge_list_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wels_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   func,
	input  logic [wels_pkg::VTX_W-1:0]   vertex_a,
	input  logic [wels_pkg::VTX_W-1:0]   vertex_b,
	input  logic signed [wels_pkg::WGT_W-1:0] weight_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [wels_pkg::VTX_W-1:0]   out_from,
	output logic [wels_pkg::VTX_W-1:0]   out_to,
	output logic signed [wels_pkg::WGT_W-1:0] out_weight,
	output logic                         last
);
	import wels_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] step_q;
	logic [CNT_W-1:0] used_q;
	logic             directed_q;
	logic [CNT_W-1:0] vcount_q;
	logic [CNT_W-1:0] elimit_q;
	logic [2:0]       func_q;
	logic [VTX_W-1:0] a_q;
	logic [VTX_W-1:0] b_q;
	logic [1:0]       pst_q;
	logic [VTX_W-1:0] pfrom_q;
	logic [VTX_W-1:0] pto_q;
	logic [WGT_W-1:0] pw_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [VTX_W-1:0] from_q;
	logic [VTX_W-1:0] to_q;
	logic [WGT_W-1:0] weight_q;
	logic             last_q;

	slot_t            cells[TABLE_SLOTS];
	slot_t            head;
	slot_t            wrap;
	slot_t            new_slot;
	logic             in_acc;
	logic             cfg_wr;
	logic [CNT_W-1:0] vc_eff;
	logic [CNT_W-1:0] lim_eff;
	logic             bad_a;
	logic             bad_b;
	logic             full;
	logic             add_ok;
	logic             out_free;
	logic             adv;
	logic             out_load;
	logic             pair_hit;
	logic             nb_hit;
	logic [VTX_W-1:0] nb_to;
	logic             emit_hit;
	logic [VTX_W-1:0] hit_from;
	logic [VTX_W-1:0] hit_to;
	logic [1:0]       st_init;
	logic [VTX_W-1:0] from_init;
	logic [VTX_W-1:0] to_init;
	logic [WGT_W-1:0] w_init;

	// Handshakes and register limits.
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign vc_eff   = (vcount_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_q;
	assign lim_eff  = (elimit_q > CNT_W'(TABLE_SLOTS)) ? CNT_W'(TABLE_SLOTS) : elimit_q;
	assign bad_a    = {1'b0, vertex_a} >= vc_eff;
	assign bad_b    = {1'b0, vertex_b} >= vc_eff;
	assign full     = used_q >= lim_eff;
	assign add_ok   = in_acc && (func == F_ADD) && !bad_a && !bad_b && !full;
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = (state_q == S_SCAN) && out_free;

	// Register readback.
	always_comb begin
		case (paddr[3:2])
			REG_DIRECTED: prdata = {31'd0, directed_q};
			REG_VCOUNT:   prdata = {25'd0, vcount_q};
			REG_ELIMIT:   prdata = {25'd0, elimit_q};
			default:      prdata = 32'd0;
		endcase
	end

	// Matching at the head of the ring.
	assign head = cells[0];
	assign pair_hit = head.valid &&
		((head.from_v == a_q && head.to_v == b_q) ||
		 (!directed_q && head.from_v == b_q && head.to_v == a_q));
	assign nb_hit = head.valid && ((head.from_v == a_q) || (!directed_q && head.to_v == a_q));
	assign nb_to  = (head.from_v == a_q) ? head.to_v : head.from_v;
	assign emit_hit = ((func_q == F_NBR) && nb_hit) || ((func_q == F_LIST) && head.valid);
	assign hit_from = (func_q == F_NBR) ? a_q : head.from_v;
	assign hit_to   = (func_q == F_NBR) ? nb_to : head.to_v;

	// A word enters the output register on a held-back scan hit or at the end.
	assign out_load = (adv && emit_hit && pst_q == ST_OK) || (state_q == S_FIN && out_free);

	// The head slot re-enters at the tail; a remove drops its valid bit.
	always_comb begin
		wrap = head;
		wrap.valid = head.valid && !((func_q == F_REMOVE) && pair_hit);
	end

	assign new_slot = '{valid: 1'b1, from_v: vertex_a, to_v: vertex_b, weight: weight_in};

	// Ring of edge cells.
	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		slot_t nxt;
		if (i == TABLE_SLOTS - 1) begin : g_tail
			assign nxt = wrap;
		end else begin : g_mid
			assign nxt = cells[i+1];
		end
		wels_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (adv),
			.load_en   (add_ok && (used_q == CNT_W'(i))),
			.load_data (new_slot),
			.shift_in  (nxt),
			.slot_q    (cells[i])
		);
	end

	// Pending result as an accepted word starts its operation.
	always_comb begin
		st_init   = ST_NONE;
		from_init = vertex_a;
		to_init   = vertex_b;
		w_init    = '0;
		case (func)
			F_ADD: begin
				if (bad_a || bad_b) begin
					st_init = ST_BADV;
				end else if (full) begin
					st_init = ST_FULL;
				end else begin
					st_init = ST_OK;
					w_init  = weight_in;
				end
			end
			F_REMOVE, F_LOOKUP: begin
				if (bad_a || bad_b) begin
					st_init = ST_BADV;
				end
			end
			F_NBR: begin
				if (bad_a) begin
					st_init = ST_BADV;
				end else begin
					to_init = '0;
				end
			end
			default: begin
				from_init = '0;
				to_init   = '0;
			end
		endcase
	end

	// Control state, fill count and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			directed_q  <= 1'b0;
			vcount_q    <= CNT_W'(MAX_VERTICES);
			elimit_q    <= CNT_W'(TABLE_SLOTS);
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_DIRECTED: directed_q <= pwdata[0];
					REG_VCOUNT:   vcount_q   <= pwdata[CNT_W-1:0];
					REG_ELIMIT:   elimit_q   <= pwdata[CNT_W-1:0];
					default:      ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (add_ok) begin
				used_q <= used_q + CNT_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						step_q <= '0;
						if ((func == F_REMOVE || func == F_LOOKUP) && !bad_a && !bad_b) begin
							state_q <= S_SCAN;
						end else if ((func == F_NBR && !bad_a) || func == F_LIST) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (adv) begin
						step_q <= step_q + IDX_W'(1);
						if (step_q == IDX_W'(TABLE_SLOTS - 1)) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Pending result and output word.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					func_q  <= func;
					a_q     <= vertex_a;
					b_q     <= vertex_b;
					pst_q   <= st_init;
					pfrom_q <= from_init;
					pto_q   <= to_init;
					pw_q    <= w_init;
				end
			end
			S_SCAN: begin
				if (adv) begin
					if (emit_hit) begin
						if (pst_q == ST_OK) begin
							status_q <= pst_q;
							from_q   <= pfrom_q;
							to_q     <= pto_q;
							weight_q <= pw_q;
							last_q   <= 1'b0;
						end
						pst_q   <= ST_OK;
						pfrom_q <= hit_from;
						pto_q   <= hit_to;
						pw_q    <= head.weight;
					end else if ((func_q == F_REMOVE) && pair_hit) begin
						pst_q <= ST_OK;
					end else if ((func_q == F_LOOKUP) && pair_hit && pst_q != ST_OK) begin
						pst_q <= ST_OK;
						pw_q  <= head.weight;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					status_q <= pst_q;
					from_q   <= pfrom_q;
					to_q     <= pto_q;
					weight_q <= pw_q;
					last_q   <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_from   = from_q;
	assign out_to     = to_q;
	assign out_weight = weight_q;
	assign last       = last_q;

	// Checks.
	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_SLOTS)) else $error("fill count above table size");
	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		add_ok |=> used_q == $past(used_q) + CNT_W'(1)) else $error("fill count slip");
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> step_q == '0) else $error("step count not home");
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && step_q == IDX_W'(TABLE_SLOTS - 1)) |=> state_q == S_FIN)
		else $error("scan did not finish");
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> out_valid_q && last_q)
		else $error("final word missing");

endmodule
